// ===== rtl/crc16lf_pkg.sv =====
package crc16lf_pkg;

	// Byte classes seen by the line state machine
	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_NEWLINE,
		KIND_COMMA,
		KIND_HEX
	} byte_kind_t;

	// One classified byte as it travels from front to back
	typedef struct packed {
		byte_kind_t  kind;
		logic [3:0]  digit;
		logic [7:0]  data;
	} rx_item_t;

	// Line verdict codes
	typedef enum logic [2:0] {
		VERDICT_OK       = 3'd0,
		VERDICT_NO_COMMA = 3'd1,
		VERDICT_SHORT    = 3'd2,
		VERDICT_MISMATCH = 3'd3,
		VERDICT_OVERFLOW = 3'd4
	} verdict_t;

	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [7:0]  BYTE_NEWLINE = 8'h0A;
	localparam logic [7:0]  BYTE_COMMA   = 8'h2C;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// Fold one byte into a reflected CRC-16
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/crc16lf_front.sv =====
module crc16lf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	output logic                  push,
	output crc16lf_pkg::rx_item_t push_item,
	input  logic                  queue_full
);
	import crc16lf_pkg::*;

	rx_item_t item_d;
	rx_item_t item_s1;
	logic     valid_s1;

	// Classify the incoming byte
	always_comb begin
		item_d.kind  = KIND_OTHER;
		item_d.digit = 4'd0;
		item_d.data  = rx_byte;
		if (rx_byte == BYTE_NEWLINE) begin
			item_d.kind = KIND_NEWLINE;
		end else if (rx_byte == BYTE_COMMA) begin
			item_d.kind = KIND_COMMA;
		end else if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
			item_d.kind  = KIND_HEX;
			item_d.digit = rx_byte[3:0];
		end else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) ||
		             (rx_byte >= 8'h61 && rx_byte <= 8'h66)) begin
			item_d.kind  = KIND_HEX;
			item_d.digit = rx_byte[3:0] + 4'd9;
		end
	end

	// Stage register drains into the queue whenever it has room
	assign push      = valid_s1 && !queue_full;
	assign push_item = item_s1;
	assign in_ready  = !valid_s1 || !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== rtl/crc16lf_queue.sv =====
module crc16lf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  crc16lf_pkg::rx_item_t push_item,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output crc16lf_pkg::rx_item_t head_item
);
	import crc16lf_pkg::*;

	rx_item_t              entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/crc16lf_back.sv =====
module crc16lf_back #(
	parameter int MAX_LINE_BYTES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  crc16lf_pkg::rx_item_t q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            verdict,
	output logic [8:0]            payload_length,
	output logic [15:0]           received_check,
	output logic [15:0]           computed_check
);
	import crc16lf_pkg::*;

	localparam int LW = $clog2(MAX_LINE_BYTES + 1);
	localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_LINE_BYTES);
	localparam logic [8:0]    PLEN_SAT = 9'(MAX_LINE_BYTES);

	logic [15:0]   crc_q;
	logic [15:0]   snap_q;
	logic          comma_seen_q;
	logic [15:0]   hex_acc_q;
	logic [2:0]    hex_cnt_q;
	logic          hex_open_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] plen_comma_q;
	logic          overflow_q;

	logic          out_valid_q;
	verdict_t      verdict_q;
	logic [8:0]    plen_out_q;
	logic [15:0]   rx_out_q;
	logic [15:0]   calc_out_q;

	logic          is_newline;
	logic          load_out;
	verdict_t      verdict_d;
	logic [8:0]    plen_d;
	logic [15:0]   rx_d;
	logic [15:0]   calc_d;
	logic [LW+8:0] plen_ext;

	// Pop unless a newline would overwrite an untaken result
	assign is_newline = (q_item.kind == KIND_NEWLINE);
	assign q_pop      = q_valid && (!is_newline || !out_valid_q || out_ready);
	assign load_out   = q_pop && is_newline;
	assign plen_ext   = {9'd0, plen_comma_q};

	// Form the line verdict
	always_comb begin
		verdict_d = VERDICT_OK;
		plen_d    = 9'd0;
		rx_d      = 16'd0;
		calc_d    = 16'd0;
		if (overflow_q) begin
			verdict_d = VERDICT_OVERFLOW;
			plen_d    = PLEN_SAT;
		end else if (!comma_seen_q) begin
			verdict_d = VERDICT_NO_COMMA;
		end else begin
			plen_d = plen_ext[8:0];
			rx_d   = hex_acc_q;
			calc_d = ~snap_q;
			if (hex_cnt_q < 3'd4) begin
				verdict_d = VERDICT_SHORT;
			end else if (hex_acc_q != ~snap_q) begin
				verdict_d = VERDICT_MISMATCH;
			end
		end
	end

	// Line state: clear at newline, overflow at the cap then hold, else fold in byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= CRC_INIT;
			snap_q       <= 16'd0;
			comma_seen_q <= 1'b0;
			hex_acc_q    <= 16'd0;
			hex_cnt_q    <= 3'd0;
			hex_open_q   <= 1'b0;
			len_q        <= '0;
			plen_comma_q <= '0;
			overflow_q   <= 1'b0;
		end else if (q_pop) begin
			if (is_newline) begin
				crc_q        <= CRC_INIT;
				snap_q       <= 16'd0;
				comma_seen_q <= 1'b0;
				hex_acc_q    <= 16'd0;
				hex_cnt_q    <= 3'd0;
				hex_open_q   <= 1'b0;
				len_q        <= '0;
				plen_comma_q <= '0;
				overflow_q   <= 1'b0;
			end else if (!overflow_q) begin
				if (len_q == LEN_MAX) begin
					overflow_q <= 1'b1;
				end else begin
					if (q_item.kind == KIND_COMMA) begin
						snap_q       <= crc_q;
						plen_comma_q <= len_q;
						comma_seen_q <= 1'b1;
						hex_acc_q    <= 16'd0;
						hex_cnt_q    <= 3'd0;
						hex_open_q   <= 1'b1;
					end else if (hex_open_q) begin
						if (q_item.kind == KIND_HEX) begin
							hex_acc_q <= {hex_acc_q[11:0], q_item.digit};
							if (hex_cnt_q != 3'd7) begin
								hex_cnt_q <= hex_cnt_q + 3'd1;
							end
						end else begin
							hex_open_q <= 1'b0;
						end
					end
					crc_q <= crc16_byte(crc_q, q_item.data);
					len_q <= len_q + 1'b1;
				end
			end
		end
	end

	// Output register: load on newline, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			verdict_q  <= verdict_d;
			plen_out_q <= plen_d;
			rx_out_q   <= rx_d;
			calc_out_q <= calc_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign payload_length = plen_out_q;
	assign received_check = rx_out_q;
	assign computed_check = calc_out_q;

endmodule

// ===== rtl/crc16_text_line_frame_checker_top.sv =====
// With the queue empty, a newline's result goes through the stage register, queue entry and
// output register. One byte per cycle is taken while the queue has room; the CRC byte
// update is combinational. A 4-entry queue between classifier and line engine absorbs
// output stalls; a newline waits in the queue while the previous result is still untaken.
// Reset (arst_n low, asynchronous): queue empty, no result pending, line state cleared
// with the CRC at FFFF.
module crc16_text_line_frame_checker_top #(
	parameter int MAX_LINE_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  verdict,
	output logic [8:0]  payload_length,
	output logic [15:0] received_check,
	output logic [15:0] computed_check
);
	import crc16lf_pkg::*;

	logic     push;
	rx_item_t push_item;
	logic     queue_full;
	logic     pop;
	logic     not_empty;
	rx_item_t head_item;

	crc16lf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	crc16lf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head_item (head_item)
	);

	crc16lf_back #(
		.MAX_LINE_BYTES (MAX_LINE_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (not_empty),
		.q_item         (head_item),
		.q_pop          (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.verdict        (verdict),
		.payload_length (payload_length),
		.received_check (received_check),
		.computed_check (computed_check)
	);

endmodule

// ===== rtl/crc16lf_checker.sv =====
module crc16lf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  verdict,
	input logic [8:0]  payload_length,
	input logic [15:0] received_check,
	input logic [15:0] computed_check
);
	import crc16lf_pkg::*;

	// Stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Stalled result keeps its verdict and checks
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(verdict) && $stable(received_check)
			&& $stable(computed_check))
		else $error("result changed while stalled");

	// An ok line carries matching checks
	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VERDICT_OK |-> received_check == computed_check)
		else $error("ok verdict with differing checks");

	// A line without comma reports nothing else
	a_no_comma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VERDICT_NO_COMMA |->
			payload_length == 9'd0 && received_check == 16'd0 && computed_check == 16'd0)
		else $error("no-comma verdict with nonzero fields");

	// An overflowed line reports no checks
	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VERDICT_OVERFLOW |->
			received_check == 16'd0 && computed_check == 16'd0)
		else $error("overflow verdict with nonzero checks");

endmodule

bind crc16_text_line_frame_checker_top crc16lf_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.verdict        (verdict),
	.payload_length (payload_length),
	.received_check (received_check),
	.computed_check (computed_check)
);
